### rtl/stereo_feedback_delay_fx_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo feedback delay
// Shared concurrent checks, clocked on clk_i and muted while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_FX_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_FX_MACROS_SVH

// Condition must hold at every clock edge.
`define SFD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger at one edge implies the consequence at the next edge.
`define SFD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/sfdfx_pkg.sv
// ----------------------------------------------------------------------------
// sfdfx_pkg
// Types, constants and arithmetic helpers of the stereo feedback delay.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdfx_pkg;

  localparam int unsigned GLIDE_SHIFT = 6;

  localparam logic [14:0] FB_MAX        = 15'd24576;
  localparam logic [14:0] ALPHA_RESET   = 15'd12801;
  localparam logic [19:0] TAIL_RESET    = 20'd88200;
  localparam logic [15:0] DELAY_RESET   = 16'd1;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;

  typedef enum logic [2:0] {
    REG_WET   = 3'd0,
    REG_FB    = 3'd1,
    REG_DELAY = 3'd2,
    REG_ALPHA = 3'd3,
    REG_TAIL  = 3'd4
  } reg_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL1 = 6'b000100,
    S_ACC  = 6'b001000,
    S_MUL2 = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Per-item sequencing strobes from the controller to both lanes.
  typedef struct packed {
    logic load;
    logic clear;
    logic rd;
    logic mul1;
    logic acc;
    logic mul2;
    logic wr;
    logic act;
    logic on;
    logic rd_valid;
  } step_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else if (v < 34'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Move cur toward tgt by delta/64 (toward zero), at least one step.
  function automatic logic [14:0] glide(input logic [14:0] cur, input logic [14:0] tgt);
    logic signed [16:0] delta;
    logic signed [16:0] stp;
    delta = $signed({2'b00, tgt}) - $signed({2'b00, cur});
    if (delta < 0) begin
      stp = -((-delta) >>> GLIDE_SHIFT);
    end else begin
      stp = delta >>> GLIDE_SHIFT;
    end
    if (stp == 17'sd0 && delta != 17'sd0) begin
      stp = (delta < 0) ? -17'sd1 : 17'sd1;
    end
    return cur + stp[14:0];
  endfunction

endpackage

`default_nettype wire

### rtl/sfdfx_lane.sv
// ----------------------------------------------------------------------------
// sfdfx_lane
// One audio channel: delay memory, damping filter and shared Q15 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdfx_lane #(
  parameter int unsigned LINE_DEPTH = 65536,
  parameter int unsigned AW = $clog2(LINE_DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire sfdfx_pkg::step_t     step_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic signed [15:0]   sample_i,
  input  wire logic [14:0]          wet_i,
  input  wire logic [14:0]          fb_i,
  input  wire logic [14:0]          alpha_i,
  output logic signed [15:0]        sample_o
);
  import sfdfx_pkg::*;

  logic signed [15:0] mem_q [LINE_DEPTH];
  logic signed [15:0] rdat_q;
  logic signed [15:0] in_q;
  logic signed [15:0] res_q;
  logic signed [15:0] damp_q;
  logic signed [31:0] pa_q;
  logic signed [32:0] pb_q;

  logic signed [15:0] dl;
  logic signed [15:0] mul_x;
  logic signed [15:0] mul_g;
  logic signed [31:0] prod;
  logic signed [16:0] diff;
  logic signed [32:0] prod_b;
  logic signed [15:0] wdata;

  assign dl     = step_i.rd_valid ? rdat_q : 16'sd0;
  assign mul_x  = step_i.mul2 ? damp_q : dl;
  assign mul_g  = $signed({1'b0, (step_i.mul2 ? fb_i : wet_i)});
  assign prod   = mul_x * mul_g;
  assign diff   = 17'(dl) - 17'(damp_q);
  assign prod_b = diff * $signed({1'b0, alpha_i});
  assign wdata  = sat16(34'(step_i.on ? in_q : 16'sd0) + 34'(pa_q >>> 15));

  always_ff @(posedge clk_i) begin
    if (step_i.wr) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (step_i.rd) begin
      rdat_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.load) begin
      in_q <= sample_i;
    end
    if (step_i.mul1 || step_i.mul2) begin
      pa_q <= prod;
    end
    if (step_i.mul1) begin
      pb_q <= prod_b;
    end
    if (step_i.acc) begin
      res_q <= sat16(34'(in_q) + 34'(pa_q >>> 15));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q <= '0;
    end else if (step_i.clear) begin
      damp_q <= '0;
    end else if (step_i.acc) begin
      damp_q <= sat16(34'(damp_q) + 34'(pb_q >>> 15));
    end
  end

  assign sample_o = step_i.act ? res_q : in_q;

endmodule

`default_nettype wire

### rtl/sfdfx_ctrl.sv
// ----------------------------------------------------------------------------
// sfdfx_ctrl
// Registers, enable edges, gain glide, tail count, line pointers and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdfx_ctrl #(
  parameter int unsigned LINE_DEPTH = 65536,
  parameter int unsigned AW = $clog2(LINE_DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             effect_on_i,
  input  wire logic             out_free_i,
  output logic                  out_load_o,
  output logic                  ringing_o,
  input  wire logic             cfg_valid_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [19:0]      cfg_data_i,
  output sfdfx_pkg::step_t      step_o,
  output logic [AW-1:0]         rd_addr_o,
  output logic [AW-1:0]         wr_addr_o,
  output logic [14:0]           wet_o,
  output logic [14:0]           fb_o,
  output logic [14:0]           alpha_o
);
  import sfdfx_pkg::*;

  localparam int unsigned PW = (AW > 16 ? AW : 16) + 1;

  state_e      state_q, state_d;
  logic [14:0] wet_tgt_q, fb_tgt_q, alpha_q;
  logic [15:0] delay_q;
  logic [19:0] tail_len_q, tail_q, tail_next, tail_d;
  logic [14:0] wet_now_q, fb_now_q;
  logic [AW-1:0] wp_q, rd_q, wp_eff, rd_d;
  logic        wrapped_q, wrapped_eff;
  logic        was_on_q, on_q, act_q, rdv_q, ring_q;
  logic        accept, rising, falling, active;
  logic [PW-1:0] wpx, dx, rdx;
  logic [14:0] fb_wr;
  logic [15:0] dly_wr;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign rising  = effect_on_i && !was_on_q;
  assign falling = !effect_on_i && was_on_q;

  assign tail_next = rising ? '0 : (falling ? tail_len_q : tail_q);
  assign active    = effect_on_i || (tail_next != '0);
  assign tail_d    = (!effect_on_i && tail_next != '0) ? tail_next - 20'd1 : tail_next;

  assign wp_eff      = rising ? '0 : wp_q;
  assign wrapped_eff = rising ? 1'b0 : wrapped_q;
  assign wpx = PW'(wp_eff);
  assign dx  = PW'(delay_q);
  assign rdx = (wpx >= dx) ? wpx - dx : wpx + PW'(LINE_DEPTH) - dx;
  assign rd_d = rdx[AW-1:0];

  // Config write shaping.
  assign fb_wr = (cfg_data_i[14:0] > FB_MAX) ? FB_MAX : cfg_data_i[14:0];
  always_comb begin
    dly_wr = cfg_data_i[15:0];
    if (dly_wr == '0) begin
      dly_wr = 16'd1;
    end
    if (21'(dly_wr) >= 21'(LINE_DEPTH)) begin
      dly_wr = 16'(LINE_DEPTH - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_tgt_q  <= '0;
      fb_tgt_q   <= '0;
      delay_q    <= DELAY_RESET;
      alpha_q    <= ALPHA_RESET;
      tail_len_q <= TAIL_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WET:   wet_tgt_q  <= cfg_data_i[14:0];
        REG_FB:    fb_tgt_q   <= fb_wr;
        REG_DELAY: delay_q    <= dly_wr;
        REG_ALPHA: alpha_q    <= cfg_data_i[14:0];
        REG_TAIL:  tail_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = active ? S_RD : S_DONE;
      S_RD:   state_d = S_MUL1;
      S_MUL1: state_d = S_ACC;
      S_ACC:  state_d = S_MUL2;
      S_MUL2: state_d = S_DONE;
      S_DONE: if (out_free_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      was_on_q  <= 1'b0;
      on_q      <= 1'b0;
      act_q     <= 1'b0;
      rdv_q     <= 1'b0;
      ring_q    <= 1'b0;
      tail_q    <= '0;
      wet_now_q <= '0;
      fb_now_q  <= '0;
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      rd_q      <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        was_on_q <= effect_on_i;
        on_q     <= effect_on_i;
        act_q    <= active;
        rdv_q    <= wrapped_eff || (rd_d < wp_eff);
        rd_q     <= rd_d;
        ring_q   <= active && (tail_d != '0);
        tail_q   <= active ? tail_d : tail_next;
        if (rising) begin
          wp_q      <= '0;
          wrapped_q <= 1'b0;
        end
        if (active) begin
          wet_now_q <= glide(rising ? wet_tgt_q : wet_now_q, wet_tgt_q);
          fb_now_q  <= glide(rising ? fb_tgt_q : fb_now_q, fb_tgt_q);
        end
      end
      // Advance the write pointer once the line entry is stored.
      if (state_q == S_DONE && out_free_i && act_q) begin
        if (wp_q == AW'(LINE_DEPTH - 1)) begin
          wp_q      <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
      end
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load_o = (state_q == S_DONE) && out_free_i;
  assign ringing_o  = ring_q;
  assign rd_addr_o  = rd_q;
  assign wr_addr_o  = wp_q;
  assign wet_o      = wet_now_q;
  assign fb_o       = fb_now_q;
  assign alpha_o    = alpha_q;

  always_comb begin
    step_o.load     = accept;
    step_o.clear    = accept && rising;
    step_o.rd       = (state_q == S_RD);
    step_o.mul1     = (state_q == S_MUL1);
    step_o.acc      = (state_q == S_ACC);
    step_o.mul2     = (state_q == S_MUL2);
    step_o.wr       = out_load_o && act_q;
    step_o.act      = act_q;
    step_o.on       = on_q;
    step_o.rd_valid = rdv_q;
  end

`include "stereo_feedback_delay_fx_macros.svh"

  `SFD_ASSERT_ALWAYS(a_state_onehot, $onehot(state_q), "sequencer state not one-hot")
  `SFD_ASSERT_ALWAYS(a_delay_range, delay_q != '0 && 21'(delay_q) < 21'(LINE_DEPTH), "bad delay")
  `SFD_ASSERT_NEXT(a_done_leaves, (state_q == S_DONE) && out_free_i, state_q == S_IDLE, "done held")
  `SFD_ASSERT_NEXT(a_pass_no_ring, accept && !active, !ring_q && (state_q == S_DONE), "idle ringing")

endmodule

`default_nettype wire

### rtl/stereo_feedback_delay_fx.sv
// ----------------------------------------------------------------------------
// stereo_feedback_delay_fx
// Stereo feedback delay with damped feedback, gain glide and ring-out tail.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one stereo frame and the
//   effect enable per item. Output channel (out_valid_o / out_stall_i) returns
//   one processed frame per input item, in order.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index and data) are always
//   taken; issue them only while no item is in flight.
//   Sequence: an active item goes through line read, multiply, accumulate,
//   feedback multiply, then line write with output load into the output
//   register; an idle pass-through item goes straight to the output load.
//   A new item is taken only once the last one is done: the five sequencer
//   steps while the effect runs, the done step alone for an idle item.
//   Reset: registers take their defaults, gains and filters clear and the line
//   reads as silence. The line needs no clearing pass: entries not yet written
//   since reset or an engage are masked by the write pointer and a wrap flag.
//   A stalled output holds its item; the block then completes at most one
//   more item internally and holds input stall until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_delay_fx #(
  parameter int unsigned LINE_DEPTH = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] left_in_i,
  input  wire logic signed [15:0] right_in_i,
  input  wire logic               effect_on_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      left_out_o,
  output logic signed [15:0]      right_out_o,
  output logic                    ringing_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [19:0]        cfg_data_i
);
  import sfdfx_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  step_t              step;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [14:0]        wet, fb, alpha;
  logic               out_free, out_load, ring;
  logic signed [15:0] left_lane, right_lane;
  logic               out_valid_q;
  logic signed [15:0] left_q, right_q;
  logic               ring_q;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  sfdfx_ctrl #(
    .LINE_DEPTH(LINE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .effect_on_i (effect_on_i),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .ringing_o   (ring),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_o      (step),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wet_o       (wet),
    .fb_o        (fb),
    .alpha_o     (alpha)
  );

  // Two identical lanes, one per channel, stepped in lockstep.
  sfdfx_lane #(
    .LINE_DEPTH(LINE_DEPTH),
    .AW(AW)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .sample_i  (left_in_i),
    .wet_i     (wet),
    .fb_i      (fb),
    .alpha_i   (alpha),
    .sample_o  (left_lane)
  );

  sfdfx_lane #(
    .LINE_DEPTH(LINE_DEPTH),
    .AW(AW)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .sample_i  (right_in_i),
    .wet_i     (wet),
    .fb_i      (fb),
    .alpha_i   (alpha),
    .sample_o  (right_lane)
  );

  // Merge both lanes and the tail flag into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      left_q  <= left_lane;
      right_q <= right_lane;
      ring_q  <= ring;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_q;
  assign right_out_o = right_q;
  assign ringing_o   = ring_q;

endmodule

`default_nettype wire
